// ===== hw/rtl/rewp_pkg.sv =====
package rewp_pkg;

    // widths of the word fields
    localparam int WORD_W   = 32;
    localparam int AMP_W    = 14;
    localparam int CNT_W    = 32;
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 2;
    localparam int CHAN_W   = 5;

    // amplitude store depth, 8 to 32 entries
    localparam int CHANNEL_SLOTS = 8;
    localparam int CH_IDX_W      = $clog2(CHANNEL_SLOTS);
    localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNEL_SLOTS);

    // store entries that feed the result and the double-event check
    localparam int ENT_GRID_A = 6;
    localparam int ENT_WIRE_A = 2;
    localparam int ENT_GRID_B = 7;
    localparam int ENT_WIRE_B = 3;
    localparam int ENT_DBL_0  = 1;
    localparam int ENT_DBL_1  = 2;
    localparam int ENT_DBL_2  = 3;
    localparam int ENT_DBL_3  = 4;

    // word signatures in bits 31:30
    localparam logic [1:0] SIG_DATA   = 2'b00;
    localparam logic [1:0] SIG_HEADER = 2'b01;
    localparam logic [1:0] SIG_FOOTER = 2'b11;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_EVENT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA_ERR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOOTER_ERR = 2'd2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_DOUBLE_THRESHOLD = '0;
    localparam logic [AMP_W-1:0]   THRESHOLD_RESET      = 14'd150;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [AMP_W-1:0]    amp_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [STATUS_W-1:0] status_t;

    typedef struct packed {
        amp_t double_threshold;
    } cfg_t;

endpackage

// ===== hw/rtl/rewp_ifs.sv =====
// readout word channel
interface rewp_in_if;
    logic           valid;
    logic           ready;
    rewp_pkg::word_t data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

// result word channel
interface rewp_out_if;
    logic              valid;
    logic              ready;
    rewp_pkg::status_t status;
    rewp_pkg::amp_t    grid_a;
    rewp_pkg::amp_t    wire_a;
    rewp_pkg::amp_t    grid_b;
    rewp_pkg::amp_t    wire_b;
    logic              double_event;
    rewp_pkg::cnt_t    event_total;
    rewp_pkg::cnt_t    double_total;
    rewp_pkg::cnt_t    error_total;
    rewp_pkg::cnt_t    words_seen;

    modport source (output valid, output status, output grid_a, output wire_a,
                    output grid_b, output wire_b, output double_event,
                    output event_total, output double_total, output error_total,
                    output words_seen, input ready);
    modport sink   (input valid, input status, input grid_a, input wire_a,
                    input grid_b, input wire_b, input double_event,
                    input event_total, input double_total, input error_total,
                    input words_seen, output ready);
endinterface

// ===== hw/rtl/rewp_regs.sv =====
module rewp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rewp_pkg::PADDR_W-1:0]  paddr,
    input  logic [rewp_pkg::PDATA_W-1:0]  pwdata,
    output logic [rewp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output rewp_pkg::cfg_t                cfg
);
    import rewp_pkg::*;

    amp_t               threshold_reg;
    logic               wr_en;
    logic [PADDR_W-3:0] reg_idx;

    // word address decode
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (wr_en && (reg_idx == REG_DOUBLE_THRESHOLD))
        begin
            threshold_reg <= pwdata[AMP_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_DOUBLE_THRESHOLD: prdata = PDATA_W'(threshold_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.double_threshold = threshold_reg;

endmodule

// ===== hw/rtl/readout_event_word_parser_core.sv =====
// a result word is registered and appears in the cycle after the word that causes it
// throughput: one word per cycle unless stalled; the parser state and the amplitude
//   store update in the same cycle the word is accepted, so words stream back to back
// input stalls only while the single result register is full and not being taken
// reset (rst_n, asynchronous, active low): idle awaiting header, store and counters
//   zero, threshold 150
module readout_event_word_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    rewp_in_if.sink                       word_in,
    rewp_out_if.source                    result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rewp_pkg::PADDR_W-1:0]  paddr,
    input  logic [rewp_pkg::PDATA_W-1:0]  pwdata,
    output logic [rewp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import rewp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DATA   = 3'b010,
        PH_FOOTER = 3'b100
    } phase_t;

    cfg_t cfg;

    phase_t              phase_reg,  phase_next;
    logic [SLOT_W-1:0]   slots_reg,  slots_next;
    amp_t                store_reg   [CHANNEL_SLOTS];
    amp_t                store_next  [CHANNEL_SLOTS];
    cnt_t                event_cnt_reg,  event_cnt_next;
    cnt_t                double_cnt_reg, double_cnt_next;
    cnt_t                error_cnt_reg,  error_cnt_next;
    cnt_t                word_cnt_reg,   word_cnt_next;

    logic                res_valid_reg, res_valid_next;
    status_t             status_reg,    status_next;
    amp_t                grid_a_reg,    grid_a_next;
    amp_t                wire_a_reg,    wire_a_next;
    amp_t                grid_b_reg,    grid_b_next;
    amp_t                wire_b_reg,    wire_b_next;
    logic                dbl_reg,       dbl_next;
    cnt_t                ev_tot_reg,    dbl_tot_reg, err_tot_reg, seen_reg;

    logic                accept;
    logic                produce;
    logic [1:0]          sig;
    logic [CHAN_W-1:0]   chan;
    logic [SLOT_W-1:0]   n_words;
    logic                dbl_hit;

    // configuration registers
    rewp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: take a word whenever the result register is free or draining
    assign word_in.ready = !res_valid_reg || result_out.ready;
    assign accept        = word_in.valid && word_in.ready;

    // word fields
    assign sig     = word_in.data_word[31:30];
    assign chan    = word_in.data_word[20:16];
    assign n_words = word_in.data_word[SLOT_W-1:0];

    // double event when entries one to four all exceed the threshold
    assign dbl_hit = (store_reg[ENT_DBL_0] > cfg.double_threshold) &&
                     (store_reg[ENT_DBL_1] > cfg.double_threshold) &&
                     (store_reg[ENT_DBL_2] > cfg.double_threshold) &&
                     (store_reg[ENT_DBL_3] > cfg.double_threshold);

    // parser next state
    always_comb
    begin
        phase_next      = phase_reg;
        slots_next      = slots_reg;
        store_next      = store_reg;
        event_cnt_next  = event_cnt_reg;
        double_cnt_next = double_cnt_reg;
        error_cnt_next  = error_cnt_reg;
        word_cnt_next   = word_cnt_reg;
        produce         = 1'b0;
        status_next     = ST_EVENT;
        grid_a_next     = '0;
        wire_a_next     = '0;
        grid_b_next     = '0;
        wire_b_next     = '0;
        dbl_next        = 1'b0;

        if (accept)
        begin
            word_cnt_next = word_cnt_reg + 1'b1;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (sig == SIG_HEADER)
                    begin
                        for (int i = 0; i < CHANNEL_SLOTS; i++)
                        begin
                            store_next[i] = '0;
                        end
                        slots_next = (n_words != '0) ? n_words - 1'b1 : '0;
                        phase_next = (n_words > SLOT_W'(1)) ? PH_DATA : PH_FOOTER;
                    end
                end
                PH_DATA:
                begin
                    if (sig != SIG_DATA)
                    begin
                        error_cnt_next = error_cnt_reg + 1'b1;
                        produce        = 1'b1;
                        status_next    = ST_DATA_ERR;
                    end
                    else if ({1'b0, chan} < CH_LIMIT)
                    begin
                        store_next[chan[CH_IDX_W-1:0]] = word_in.data_word[AMP_W-1:0];
                    end
                    slots_next = slots_reg - 1'b1;
                    if (slots_next == '0)
                    begin
                        phase_next = PH_FOOTER;
                    end
                end
                default:
                begin
                    // footer slot
                    phase_next = PH_IDLE;
                    produce    = 1'b1;
                    if (sig != SIG_FOOTER)
                    begin
                        error_cnt_next = error_cnt_reg + 1'b1;
                        status_next    = ST_FOOTER_ERR;
                    end
                    else
                    begin
                        event_cnt_next = event_cnt_reg + 1'b1;
                        if (dbl_hit)
                        begin
                            double_cnt_next = double_cnt_reg + 1'b1;
                        end
                        status_next = ST_EVENT;
                        grid_a_next = store_reg[ENT_GRID_A];
                        wire_a_next = store_reg[ENT_WIRE_A];
                        grid_b_next = store_reg[ENT_GRID_B];
                        wire_b_next = store_reg[ENT_WIRE_B];
                        dbl_next    = dbl_hit;
                    end
                end
            endcase
        end
    end

    // result valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept && produce)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // parser state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slots_reg      <= '0;
            event_cnt_reg  <= '0;
            double_cnt_reg <= '0;
            error_cnt_reg  <= '0;
            word_cnt_reg   <= '0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNEL_SLOTS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            slots_reg      <= slots_next;
            event_cnt_reg  <= event_cnt_next;
            double_cnt_reg <= double_cnt_next;
            error_cnt_reg  <= error_cnt_next;
            word_cnt_reg   <= word_cnt_next;
            res_valid_reg  <= res_valid_next;
            store_reg      <= store_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            status_reg  <= status_next;
            grid_a_reg  <= grid_a_next;
            wire_a_reg  <= wire_a_next;
            grid_b_reg  <= grid_b_next;
            wire_b_reg  <= wire_b_next;
            dbl_reg     <= dbl_next;
            ev_tot_reg  <= event_cnt_next;
            dbl_tot_reg <= double_cnt_next;
            err_tot_reg <= error_cnt_next;
            seen_reg    <= word_cnt_next;
        end
    end

    // result word
    assign result_out.valid        = res_valid_reg;
    assign result_out.status       = status_reg;
    assign result_out.grid_a       = grid_a_reg;
    assign result_out.wire_a       = wire_a_reg;
    assign result_out.grid_b       = grid_b_reg;
    assign result_out.wire_b       = wire_b_reg;
    assign result_out.double_event = dbl_reg;
    assign result_out.event_total  = ev_tot_reg;
    assign result_out.double_total = dbl_tot_reg;
    assign result_out.error_total  = err_tot_reg;
    assign result_out.words_seen   = seen_reg;

endmodule
